// ===== hw/rtl/rrp_pkg.sv =====
// ============================================================================
// rrp_pkg
// Shared types and constants for the record-and-repeat playback block.
// ============================================================================
`default_nettype none

package rrp_pkg;

    // fixed field widths
    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int REP_W  = 8;
    localparam int CAP_W  = 13;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY_LIMIT = 1'd1;

    // reset values of the configuration registers
    localparam logic [REP_W-1:0] REPEAT_RESET = 8'd1;
    localparam logic [CAP_W-1:0] CAP_RESET    = 13'd4096;

    // input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_END    = 2'd1,
        CMD_PULL   = 2'd2
    } t_cmd;

    // operating mode
    typedef enum logic [1:0] {
        MODE_REC  = 2'd0,
        MODE_PLAY = 2'd1,
        MODE_DONE = 2'd2
    } t_mode;

    // one result item
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              from_memory;
        logic              pass_end;
        logic              finished;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/rrp_out_fifo.sv =====
// ============================================================================
// rrp_out_fifo
// Three-entry result queue between the memory read stage and the output port.
// ============================================================================
`default_nettype none

module rrp_out_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  rrp_pkg::t_result    i_push_data,
    output logic                o_valid,
    output rrp_pkg::t_result    o_data,
    input  wire                 i_pop_ready,
    output logic [1:0]          o_count
);

    localparam logic [1:0] LAST_SLOT = 2'd2;

    rrp_pkg::t_result r_slot [3];
    logic [1:0]       r_head;
    logic [1:0]       r_tail;
    logic [1:0]       r_count;
    logic [1:0]       n_head;
    logic [1:0]       n_tail;
    logic [1:0]       n_count;
    logic             w_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_head];
    assign o_count = r_count;
    assign w_pop   = o_valid && i_pop_ready;

    // pointer and fill update
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (w_pop) begin
            n_head = (r_head == LAST_SLOT) ? 2'd0 : r_head + 2'd1;
        end
        if (i_push) begin
            n_tail = (r_tail == LAST_SLOT) ? 2'd0 : r_tail + 2'd1;
        end
        if (i_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 2'd0;
            r_tail  <= 2'd0;
            r_count <= 2'd0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // payload slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_tail] <= i_push_data;
        end
    end

    // never written while full
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd3) |-> (!i_push || w_pop))
        else $error("result queue overflow");

    // fill count follows the transfers
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !w_pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("result queue count mismatch");

endmodule

`default_nettype wire

// ===== hw/rtl/record_and_repeat_playback.sv =====
// ============================================================================
// record_and_repeat_playback
// Records a live sample stream into a sample memory and replays it on request.
// ============================================================================
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: sample_data, tuser: command
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: out_data, tlast: pass_end,
//                                                tuser: from_memory, finished
//  cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
//  One item is taken per clock while s_axis_tready is high. A result reaches
//  m_axis through the read stage (synchronous sample memory read) and the result
//  queue. Up to three results may be in flight; s_axis_tready drops only
//  when all three are held. Reset clears the control state at once; the sample
//  memory is not cleared (playback reads only entries written while recording).
//  Configuration writes are always taken and act on the next item.
// ============================================================================
`default_nettype none

module record_and_repeat_playback #(
    parameter int DEPTH     = 4096,
    parameter int ITEM_BITS = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // input stream
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [rrp_pkg::DATA_W-1:0]   s_axis_tdata,   // [31:0] sample_data
    input  wire  [rrp_pkg::CMD_W-1:0]    s_axis_tuser,   // [1:0] command
    // result stream
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [rrp_pkg::DATA_W-1:0]   m_axis_tdata,   // [31:0] out_data
    output logic                         m_axis_tlast,   // pass_end
    output logic [1:0]                   m_axis_tuser,   // [0] from_memory, [1] finished
    // configuration writes
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [rrp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [rrp_pkg::CAP_W-1:0]    i_cfg_data
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_W  = (CNT_W > rrp_pkg::CAP_W) ? CNT_W : rrp_pkg::CAP_W;
    localparam int DW     = rrp_pkg::DATA_W;

    // configuration registers
    logic [rrp_pkg::REP_W-1:0] r_repeat;
    logic [rrp_pkg::CAP_W-1:0] r_cap;

    // control state
    rrp_pkg::t_mode            r_mode;
    rrp_pkg::t_mode            n_mode;
    logic [CNT_W-1:0]          r_rec_cnt;
    logic [CNT_W-1:0]          n_rec_cnt;
    logic [ADDR_W-1:0]         r_play_idx;
    logic [ADDR_W-1:0]         n_play_idx;
    logic [rrp_pkg::REP_W-1:0] r_passes;
    logic [rrp_pkg::REP_W-1:0] n_passes;

    // sample memory
    logic [ITEM_BITS-1:0]      r_mem [DEPTH];
    logic [ITEM_BITS-1:0]      r_rdata;

    // read stage
    logic                      r_s1_valid;
    logic                      n_s1_valid;
    rrp_pkg::t_result          r_s1;
    rrp_pkg::t_result          n_s1;

    logic                      w_accept;
    rrp_pkg::t_cmd             w_cmd;
    logic                      w_wr_en;
    logic                      w_rd_en;
    logic [ADDR_W-1:0]         w_rd_addr;
    logic [ITEM_BITS-1:0]      w_samp_item;
    logic [DW-1:0]             w_samp32;
    logic [DW-1:0]             w_rd32;
    logic [LIM_W-1:0]          w_cap_ext;
    logic [LIM_W-1:0]          w_limit;
    logic [LIM_W-1:0]          w_rec_ext;
    logic [LIM_W-1:0]          w_idx_ext;
    logic [rrp_pkg::REP_W-1:0] w_passes_inc;
    logic [1:0]                w_q_count;
    logic [2:0]                w_occ;
    rrp_pkg::t_result          w_push_data;
    rrp_pkg::t_result          w_q_data;

    assign w_cmd    = rrp_pkg::t_cmd'(s_axis_tuser);
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // sample width adaptation
    if (ITEM_BITS >= DW) begin : g_wide
        assign w_samp_item = ITEM_BITS'(s_axis_tdata);
        assign w_samp32    = s_axis_tdata;
        assign w_rd32      = r_rdata[DW-1:0];
    end else begin : g_narrow
        assign w_samp_item = s_axis_tdata[ITEM_BITS-1:0];
        assign w_samp32    = DW'(w_samp_item);
        assign w_rd32      = DW'(r_rdata);
    end

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat <= rrp_pkg::REPEAT_RESET;
            r_cap    <= rrp_pkg::CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rrp_pkg::CFG_REPEAT_COUNT:   r_repeat <= i_cfg_data[rrp_pkg::REP_W-1:0];
                rrp_pkg::CFG_CAPACITY_LIMIT: r_cap    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // applied capacity: the smaller of the register and the memory depth
    assign w_cap_ext = LIM_W'(r_cap);
    assign w_limit   = (w_cap_ext > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : w_cap_ext;
    assign w_rec_ext = LIM_W'(r_rec_cnt);

    // replay address wraps to the start if beyond the recording
    assign w_idx_ext = (LIM_W'(r_play_idx) >= w_rec_ext) ? '0 : LIM_W'(r_play_idx);
    assign w_rd_addr = w_idx_ext[ADDR_W-1:0];
    assign w_passes_inc = (r_passes < 8'd255) ? r_passes + 8'd1 : r_passes;

    // mode sequencing and result forming
    always_comb begin
        n_mode     = r_mode;
        n_rec_cnt  = r_rec_cnt;
        n_play_idx = r_play_idx;
        n_passes   = r_passes;
        n_s1_valid = 1'b0;
        n_s1       = '0;
        w_wr_en    = 1'b0;
        w_rd_en    = 1'b0;
        if (w_accept) begin
            unique case (r_mode)
                rrp_pkg::MODE_REC: begin
                    if (w_cmd == rrp_pkg::CMD_SAMPLE) begin
                        if (w_rec_ext < w_limit) begin
                            w_wr_en     = 1'b1;
                            n_rec_cnt   = r_rec_cnt + CNT_W'(1);
                            n_s1_valid  = 1'b1;
                            n_s1.data   = w_samp32;
                        end
                    end else if (w_cmd == rrp_pkg::CMD_END) begin
                        n_play_idx = '0;
                        n_passes   = '0;
                        if (r_repeat == 8'd1 || r_rec_cnt == '0) begin
                            n_mode = rrp_pkg::MODE_DONE;
                        end else begin
                            n_mode = rrp_pkg::MODE_PLAY;
                        end
                    end
                end
                rrp_pkg::MODE_PLAY: begin
                    if (w_cmd == rrp_pkg::CMD_PULL) begin
                        w_rd_en          = 1'b1;
                        n_s1_valid       = 1'b1;
                        n_s1.from_memory = 1'b1;
                        if (w_idx_ext + LIM_W'(1) >= w_rec_ext) begin
                            n_s1.pass_end = 1'b1;
                            n_play_idx    = '0;
                            if (r_repeat != 8'd0) begin
                                n_passes = w_passes_inc;
                                if (w_passes_inc >= r_repeat - 8'd1) begin
                                    n_mode        = rrp_pkg::MODE_DONE;
                                    n_s1.finished = 1'b1;
                                end
                            end
                        end else begin
                            n_play_idx = ADDR_W'(w_idx_ext + LIM_W'(1));
                        end
                    end
                end
                rrp_pkg::MODE_DONE: begin
                    if (w_cmd == rrp_pkg::CMD_PULL) begin
                        n_s1_valid    = 1'b1;
                        n_s1.finished = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= rrp_pkg::MODE_REC;
            r_rec_cnt  <= '0;
            r_play_idx <= '0;
            r_passes   <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_rec_cnt  <= n_rec_cnt;
            r_play_idx <= n_play_idx;
            r_passes   <= n_passes;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    // sample memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_rec_cnt[ADDR_W-1:0]] <= w_samp_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // merge read data into the result and queue it
    always_comb begin
        w_push_data = r_s1;
        if (r_s1.from_memory) begin
            w_push_data.data = w_rd32;
        end
    end

    rrp_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_valid),
        .i_push_data (w_push_data),
        .o_valid     (m_axis_tvalid),
        .o_data      (w_q_data),
        .i_pop_ready (m_axis_tready),
        .o_count     (w_q_count)
    );

    assign m_axis_tdata  = w_q_data.data;
    assign m_axis_tlast  = w_q_data.pass_end;
    assign m_axis_tuser  = {w_q_data.finished, w_q_data.from_memory};

    // credit: queued results plus the one in the read stage
    assign w_occ         = {1'b0, w_q_count} + {2'b00, r_s1_valid};
    assign s_axis_tready = (w_occ < 3'd3);

    // recording never runs past the memory
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LIM_W'(r_rec_cnt) <= LIM_W'(DEPTH)))
        else $error("recorded count beyond memory depth");

    // playback only runs over a non-empty recording
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == rrp_pkg::MODE_PLAY) |-> (r_rec_cnt != '0))
        else $error("playback with empty recording");

    // end of input always leaves recording
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_mode == rrp_pkg::MODE_REC && w_cmd == rrp_pkg::CMD_END)
        |=> (r_mode != rrp_pkg::MODE_REC))
        else $error("end of input did not close recording");

    // a replayed result reads the memory in the cycle before
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.from_memory) |-> $past(w_rd_en))
        else $error("replayed result without memory read");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for record_and_repeat_playback. Records a random sample
// stream with store-full drops, ends the recording, then pulls replay passes
// under several repeat settings until the block finishes. A scoreboard class
// predicts every result and compares it field by field with the DUT output.
// ============================================================================

module tb_top;

    localparam int            STORE_DEPTH  = 4096;
    localparam logic [1:0]    CMD_RESERVED = 2'd3;   // never a valid command
    localparam int            DRAIN_CYCLES = 10;     // > result latency + queue
    localparam int            STALL_LIMIT  = 5000;   // cycles with no transfer
    // how the recording is closed
    localparam int            PATH_EMPTY   = 0;      // nothing recorded
    localparam int            PATH_SINGLE  = 1;      // repeat_count of 1

    // ------------------------------------------------------------------------
    // Scoreboard: replay predictor plus queue of pending results
    // ------------------------------------------------------------------------
    class replay_scoreboard;
        rrp_pkg::t_result  pending_results[$];
        int                errors;
        // register copies
        logic [rrp_pkg::REP_W-1:0] repeat_total;
        logic [rrp_pkg::CAP_W-1:0] cap_limit;
        // predicted block state
        rrp_pkg::t_mode    mode;
        int unsigned       rec_count;
        int unsigned       play_idx;
        int unsigned       passes;
        logic [rrp_pkg::DATA_W-1:0] store [STORE_DEPTH];

        function new();
            errors       = 0;
            repeat_total = rrp_pkg::REPEAT_RESET;
            cap_limit    = rrp_pkg::CAP_RESET;
            mode         = rrp_pkg::MODE_REC;
            rec_count    = 0;
            play_idx     = 0;
            passes       = 0;
        endfunction

        function void note_config(logic [rrp_pkg::CFG_IDX_W-1:0] idx,
                                  logic [rrp_pkg::CAP_W-1:0] value);
            if (idx == rrp_pkg::CFG_REPEAT_COUNT)
                repeat_total = value[rrp_pkg::REP_W-1:0];
            else
                cap_limit = value;
        endfunction

        // advance the predicted state by one accepted input transfer
        function void note_item(logic [1:0] cmd, logic [rrp_pkg::DATA_W-1:0] sample);
            rrp_pkg::t_result r;
            int unsigned      lim;
            int unsigned      idx;
            case (mode)
                rrp_pkg::MODE_REC: begin
                    if (cmd == rrp_pkg::CMD_SAMPLE) begin
                        lim = (cap_limit > STORE_DEPTH) ? STORE_DEPTH : cap_limit;
                        // store full: sample dropped silently
                        if (rec_count < lim) begin
                            store[rec_count] = sample;
                            rec_count++;
                            r.data        = sample;
                            r.from_memory = 1'b0;
                            r.pass_end    = 1'b0;
                            r.finished    = 1'b0;
                            pending_results.insert(pending_results.size(), r);
                        end
                    end else if (cmd == rrp_pkg::CMD_END) begin
                        play_idx = 0;
                        passes   = 0;
                        mode = (repeat_total == 1 || rec_count == 0) ?
                               rrp_pkg::MODE_DONE : rrp_pkg::MODE_PLAY;
                    end
                end
                rrp_pkg::MODE_PLAY: begin
                    if (cmd == rrp_pkg::CMD_PULL) begin
                        idx = (play_idx >= rec_count) ? 0 : play_idx;
                        r.data        = store[idx];
                        r.from_memory = 1'b1;
                        r.pass_end    = 1'b0;
                        if (idx + 1 >= rec_count) begin
                            // end of one replay pass
                            r.pass_end = 1'b1;
                            play_idx   = 0;
                            if (repeat_total != 0) begin
                                if (passes < 255)
                                    passes++;
                                if (passes >= repeat_total - 1)
                                    mode = rrp_pkg::MODE_DONE;
                            end
                        end else begin
                            play_idx = idx + 1;
                        end
                        r.finished = (mode == rrp_pkg::MODE_DONE);
                        pending_results.insert(pending_results.size(), r);
                    end
                end
                default: begin
                    // pull after the last pass reports finished only
                    if (cmd == rrp_pkg::CMD_PULL) begin
                        r.data        = '0;
                        r.from_memory = 1'b0;
                        r.pass_end    = 1'b0;
                        r.finished    = 1'b1;
                        pending_results.insert(pending_results.size(), r);
                    end
                end
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(rrp_pkg::t_result got);
            rrp_pkg::t_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result data=%h", got.data));
            end else begin
                want = pending_results.pop_front();
                if (got.data !== want.data)
                    report($sformatf("out_data %h, want %h", got.data, want.data));
                if (got.from_memory !== want.from_memory)
                    report($sformatf("from_memory %b, want %b", got.from_memory,
                                     want.from_memory));
                if (got.pass_end !== want.pass_end)
                    report($sformatf("pass_end %b, want %b", got.pass_end, want.pass_end));
                if (got.finished !== want.finished)
                    report($sformatf("finished %b, want %b", got.finished, want.finished));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [rrp_pkg::DATA_W-1:0]     s_axis_tdata;    // [31:0] sample_data
    logic [rrp_pkg::CMD_W-1:0]      s_axis_tuser;    // [1:0] command
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [rrp_pkg::DATA_W-1:0]     m_axis_tdata;    // [31:0] out_data
    logic                           m_axis_tlast;    // pass_end
    logic [1:0]                     m_axis_tuser;    // [0] from_memory, [1] finished
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [rrp_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [rrp_pkg::CAP_W-1:0]      i_cfg_data;

    record_and_repeat_playback dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    replay_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    int quiet_cycles;

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Result side: random backpressure and checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        rrp_pkg::t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.data        = m_axis_tdata;
            got.from_memory = m_axis_tuser[0];
            got.pass_end    = m_axis_tlast;
            got.finished    = m_axis_tuser[1];
            sb.check_result(got);
        end
    end

    // watchdog: ends a run that stops moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("record_and_repeat_playback regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------
    // idle pattern moves through three regimes as the run goes on
    function void update_idling();
        if (items_sent < 500) begin
            send_idle_pct  = 12;
            recv_stall_pct = 75;
        end else if (items_sent < 1000) begin
            send_idle_pct  = 75;
            recv_stall_pct = 12;
        end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    endfunction

    task automatic send_item(input logic [1:0] cmd,
                             input logic [rrp_pkg::DATA_W-1:0] sample);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(cmd, sample);
        items_sent++;
        update_idling();
    endtask

    // stop sending and let every pending result come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rrp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rrp_pkg::CAP_W-1:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_config(idx, value);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly samples, with pulls and reserved commands mixed in
    task automatic record_burst(input int n_items);
        int pick;
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                send_item(rrp_pkg::CMD_SAMPLE, $urandom);
            else if (pick < 95)
                send_item(rrp_pkg::CMD_PULL, $urandom);
            else
                send_item(CMD_RESERVED, $urandom);
        end
    endtask

    // pulls, with the odd wrong-state command in between
    task automatic pull_burst(input int n_pulls);
        int pulls;
        int pick;
        pulls = 0;
        while (pulls < n_pulls) begin
            pick = $urandom_range(0, 99);
            if (pick < 88) begin
                send_item(rrp_pkg::CMD_PULL, $urandom);
                pulls++;
            end else if (pick < 93) begin
                send_item(rrp_pkg::CMD_SAMPLE, $urandom);
            end else if (pick < 97) begin
                send_item(rrp_pkg::CMD_END, $urandom);
            end else begin
                send_item(CMD_RESERVED, $urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int path;
        sb            = new();
        items_sent    = 0;
        quiet_cycles  = 0;
        update_idling();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= rrp_pkg::CMD_SAMPLE;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= rrp_pkg::CFG_REPEAT_COUNT;
        i_cfg_data    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        path = $urandom_range(0, 9);

        // zero capacity: every sample dropped; wrong-state commands ignored
        write_reg(rrp_pkg::CFG_CAPACITY_LIMIT, '0);
        write_reg(rrp_pkg::CFG_REPEAT_COUNT, '0);
        send_item(rrp_pkg::CMD_SAMPLE, 32'h0000_0000);
        send_item(rrp_pkg::CMD_SAMPLE, 32'hFFFF_FFFF);
        send_item(rrp_pkg::CMD_PULL, 32'h1234_5678);
        send_item(CMD_RESERVED, 32'hFFFF_FFFF);

        if (path != PATH_EMPTY) begin
            // full capacity, directed extremes of the sample value
            write_reg(rrp_pkg::CFG_CAPACITY_LIMIT, rrp_pkg::CAP_RESET);
            send_item(rrp_pkg::CMD_SAMPLE, 32'h0000_0000);
            send_item(rrp_pkg::CMD_SAMPLE, 32'hFFFF_FFFF);
            send_item(rrp_pkg::CMD_SAMPLE, 32'hAAAA_AAAA);
            send_item(rrp_pkg::CMD_SAMPLE, 32'h5555_5555);
            send_item(rrp_pkg::CMD_SAMPLE, 32'h0000_0001);
            send_item(rrp_pkg::CMD_SAMPLE, 32'h8000_0000);
            send_item(rrp_pkg::CMD_PULL, 32'h0);
            send_item(CMD_RESERVED, 32'h0);
            // small limit so the store fills and later samples drop
            write_reg(rrp_pkg::CFG_CAPACITY_LIMIT,
                      rrp_pkg::CAP_W'($urandom_range(8, 64)));
            record_burst(150);
        end

        // close the recording
        if (path == PATH_SINGLE)
            write_reg(rrp_pkg::CFG_REPEAT_COUNT, rrp_pkg::REP_W'(1));
        send_item(rrp_pkg::CMD_END, 32'hFFFF_FFFF);
        send_item(rrp_pkg::CMD_END, 32'h0);

        // replay forever, then counted passes, then a low count that finishes
        pull_burst(400);
        write_reg(rrp_pkg::CFG_REPEAT_COUNT, rrp_pkg::REP_W'(255));
        pull_burst(450);
        write_reg(rrp_pkg::CFG_REPEAT_COUNT, rrp_pkg::REP_W'($urandom_range(2, 4)));
        pull_burst(250);
        write_reg(rrp_pkg::CFG_REPEAT_COUNT, rrp_pkg::REP_W'(1));
        write_reg(rrp_pkg::CFG_CAPACITY_LIMIT, rrp_pkg::CAP_RESET);
        pull_burst(100);

        settle();
        if (sb.errors == 0)
            $display("record_and_repeat_playback regression: pass");
        else
            $display("record_and_repeat_playback regression: fail");
        $finish;
    end

endmodule
